// File: rtl/bitmap_allocator_with_area_search_assert.svh
// assertion macros for the bitmap allocator checker
// no dependencies; included by the checker file only
`ifndef BITMAP_ALLOCATOR_WITH_AREA_SEARCH_ASSERT_SVH
`define BITMAP_ALLOCATOR_WITH_AREA_SEARCH_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BAAS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap allocator check failed");

// next-cycle implication, checked at every rising edge outside reset
`define BAAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap allocator check failed");

`endif

// File: rtl/baas_pkg.sv
// shared constants, types and codes of the bitmap allocator
// no dependencies; imported by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package baas_pkg;

   // map geometry
   localparam int MAP_BITS       = 4096;
   localparam int SCAN_WORD_BITS = 64;
   localparam int IDX_W          = $clog2(MAP_BITS);
   localparam int SIZE_W         = IDX_W + 1;
   localparam int WORD_W         = $clog2(SCAN_WORD_BITS);
   localparam int ROWS           = MAP_BITS / SCAN_WORD_BITS;
   localparam int ROW_W          = IDX_W - WORD_W;
   localparam int OP_W           = 3;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_SET       = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_TEST      = 3'd2,
      OP_FIND_ZERO = 3'd3,
      OP_FIND_RUN  = 3'd4
   } op_type;

   // response status codes
   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_INVALID = 1'b1
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SEEK,
      ST_CHECK,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

// File: rtl/bitmap_allocator_with_area_search.sv
// Bitmap allocator with free-bit and aligned free-run search. The map is held
// as 64-bit words in one memory with one write and one registered read port;
// a valid bit per word makes the whole map read as clear straight after reset,
// so there is no clearing pass. One request is in flight at a time and
// req_ready is high only when the sequencer is idle; the result beat sits in an
// output register, so a new request may be taken while the last result waits.
// Set, clear and test go through read, modify-write and deliver steps. A
// free-bit search seeks one 64-bit word at a time, so up to 64 words over a
// full 4096-bit map, then checks the bit it found. A run search reads one
// word per seek or check step; each candidate start that turns out blocked
// sends the seek on to the word that holds the next aligned candidate past
// the blocking bit. Searches are paced by the single word read port, which
// the seek and check steps share.
// map_size is written on csr_write_enable and must only change while idle.
// Depends on baas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator_with_area_search (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_write_enable,
   input  wire logic [baas_pkg::SIZE_W-1:0] csr_write_data,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [baas_pkg::OP_W-1:0]   req_operation,
   input  wire logic [baas_pkg::IDX_W-1:0]  req_bit_index,
   input  wire logic [baas_pkg::SIZE_W-1:0] req_run_length,
   input  wire logic [baas_pkg::SIZE_W-1:0] req_alignment,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_status,
   output logic                             rsp_bit_value,
   output logic [baas_pkg::SIZE_W-1:0]      rsp_found_index,
   output logic [baas_pkg::SIZE_W-1:0]      rsp_set_count,
   output logic [baas_pkg::IDX_W-1:0]       rsp_last_set_index,
   output logic [baas_pkg::IDX_W-1:0]       rsp_last_clear_index
);
   import baas_pkg::*;

   // round up to the alignment mask
   function automatic logic [SIZE_W-1:0] align_up(input logic [SIZE_W-1:0] v,
                                                  input logic [IDX_W-1:0]  m);
      return (v + SIZE_W'(m)) & ~SIZE_W'(m);
   endfunction

   // position of the lowest set bit of a word
   function automatic logic [WORD_W-1:0] lowest_one(input logic [SCAN_WORD_BITS-1:0] v);
      logic [WORD_W-1:0] pos;
      pos = '0;
      for (int j = SCAN_WORD_BITS - 1; j >= 0; j--) begin
         if (v[j]) pos = WORD_W'(j);
      end
      return pos;
   endfunction

   // position of the highest set bit of a word
   function automatic logic [WORD_W-1:0] highest_one(input logic [SCAN_WORD_BITS-1:0] v);
      logic [WORD_W-1:0] pos;
      pos = '0;
      for (int j = 0; j < SCAN_WORD_BITS; j++) begin
         if (v[j]) pos = WORD_W'(j);
      end
      return pos;
   endfunction

   // sequencer and request context
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SIZE_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]    mask_ff, mask_in;
   logic [SIZE_W-1:0]   cand_ff, cand_in;
   logic [ROW_W-1:0]    wrd_ff, wrd_in;

   // result held until the output register is free
   logic                res_status_ff, res_status_in;
   logic                res_bit_ff, res_bit_in;
   logic [SIZE_W-1:0]   res_found_ff, res_found_in;

   // allocator state
   logic [SIZE_W-1:0]   map_size_ff;
   logic [SIZE_W-1:0]   set_count_ff, set_count_in;
   logic [IDX_W-1:0]    recent_set_ff, recent_set_in;
   logic [IDX_W-1:0]    recent_clear_ff, recent_clear_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic                rsp_bit_ff;
   logic [SIZE_W-1:0]   rsp_found_ff;
   logic [SIZE_W-1:0]   rsp_count_ff;
   logic [IDX_W-1:0]    rsp_set_ff;
   logic [IDX_W-1:0]    rsp_clear_ff;

   // map memory
   logic [SCAN_WORD_BITS-1:0] map_mem [ROWS];
   logic [ROWS-1:0]           row_valid_ff;
   logic [SCAN_WORD_BITS-1:0] rd_data_ff;
   logic                      rd_valid_ff;
   logic [ROW_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [SCAN_WORD_BITS-1:0] wr_data;

   // derived values
   logic [SIZE_W-1:0]         size;
   logic                      accept;
   logic                      slot_free;
   logic                      req_invalid;
   logic [IDX_W-1:0]          req_mask;
   logic [SIZE_W-1:0]         start_cand;
   logic [SCAN_WORD_BITS-1:0] word_q;
   logic [SIZE_W-1:0]         base;
   logic                      base_aligned;
   logic                      out_of_room;
   logic [SIZE_W-1:0]         run_end;
   logic                      end_here;
   logic [WORD_W-1:0]         win_lo;
   logic [WORD_W-1:0]         win_hi;
   logic [SCAN_WORD_BITS-1:0] seek_bits;
   logic [SCAN_WORD_BITS-1:0] chk_bits;
   logic                      seek_hit;
   logic                      chk_hit;
   logic [SIZE_W-1:0]         seek_cand;
   logic [SIZE_W-1:0]         next_word_cand;
   logic [SIZE_W-1:0]         jump_cand;
   logic                      cur_bit;
   logic [SCAN_WORD_BITS-1:0] bit_onehot;

   // effective map size and handshakes
   assign size      = (map_size_ff > SIZE_W'(MAP_BITS)) ? SIZE_W'(MAP_BITS) : map_size_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // request checks and search start
   assign req_mask = (req_alignment == '0) ? '0 : IDX_W'(req_alignment - 1'b1);
   always_comb begin
      req_invalid = (req_operation > OP_FIND_RUN) || ({1'b0, req_bit_index} >= size);
      if (req_operation == OP_FIND_RUN) begin
         if ((req_run_length == '0)
             || ((req_alignment & (req_alignment - 1'b1)) != '0)) begin
            req_invalid = 1'b1;
         end
      end
   end
   assign start_cand = (req_operation == OP_FIND_RUN)
                     ? align_up({1'b0, req_bit_index}, req_mask)
                     : {1'b0, req_bit_index};

   // current word and bounds of the candidate
   assign word_q       = rd_valid_ff ? rd_data_ff : '0;
   assign base         = {1'b0, wrd_ff, {WORD_W{1'b0}}};
   assign base_aligned = ((base[IDX_W-1:0] & mask_ff) == '0);
   assign out_of_room  = (cand_ff >= size) || (len_ff > (size - cand_ff));
   assign run_end      = SIZE_W'(cand_ff + len_ff - 1'b1);
   assign end_here     = (run_end[IDX_W-1:WORD_W] == wrd_ff);
   assign win_lo       = (cand_ff[IDX_W-1:WORD_W] == wrd_ff) ? cand_ff[WORD_W-1:0] : '0;
   assign win_hi       = end_here ? run_end[WORD_W-1:0] : '1;

   // seek: aligned clear bits at or after the candidate; check: set bits in the run
   always_comb begin
      for (int j = 0; j < SCAN_WORD_BITS; j++) begin
         seek_bits[j] = !word_q[j] && base_aligned
                     && ((WORD_W'(j) & mask_ff[WORD_W-1:0]) == '0)
                     && (WORD_W'(j) >= cand_ff[WORD_W-1:0]);
         chk_bits[j]  = word_q[j] && (WORD_W'(j) >= win_lo) && (WORD_W'(j) <= win_hi);
      end
   end
   assign seek_hit       = |seek_bits;
   assign chk_hit        = |chk_bits;
   assign seek_cand      = base + SIZE_W'(lowest_one(seek_bits));
   assign next_word_cand = align_up(SIZE_W'(base + SIZE_W'(SCAN_WORD_BITS)), mask_ff);
   assign jump_cand      = align_up(SIZE_W'(base + SIZE_W'(highest_one(chk_bits)) + 1'b1),
                                    mask_ff);

   // single-bit access
   assign cur_bit    = word_q[idx_ff[WORD_W-1:0]];
   assign bit_onehot = SCAN_WORD_BITS'(1) << idx_ff[WORD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_invalid) begin
                  state_in = ST_DELIVER;
               end else if (req_operation == OP_FIND_ZERO || req_operation == OP_FIND_RUN) begin
                  state_in = ST_SEEK;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            state_in = ST_DELIVER;
         end
         ST_SEEK: begin
            priority if (out_of_room) state_in = ST_DELIVER;
            else if (seek_hit)        state_in = ST_CHECK;
            else                      state_in = ST_SEEK;
         end
         ST_CHECK: begin
            priority if (out_of_room) state_in = ST_DELIVER;
            else if (chk_hit)         state_in = ST_SEEK;
            else if (end_here)        state_in = ST_DELIVER;
            else                      state_in = ST_CHECK;
         end
         ST_DELIVER: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in           = op_ff;
      idx_in          = idx_ff;
      len_in          = len_ff;
      mask_in         = mask_ff;
      cand_in         = cand_ff;
      wrd_in          = wrd_ff;
      res_status_in   = res_status_ff;
      res_bit_in      = res_bit_ff;
      res_found_in    = res_found_ff;
      set_count_in    = set_count_ff;
      recent_set_in   = recent_set_ff;
      recent_clear_in = recent_clear_ff;
      wr_en           = 1'b0;
      wr_data         = word_q;
      rd_addr         = wrd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            op_in         = op_type'(req_operation);
            idx_in        = req_bit_index;
            len_in        = (req_operation == OP_FIND_RUN) ? req_run_length : SIZE_W'(1);
            mask_in       = (req_operation == OP_FIND_RUN) ? req_mask : '0;
            cand_in       = start_cand;
            wrd_in        = start_cand[IDX_W-1:WORD_W];
            rd_addr       = start_cand[IDX_W-1:WORD_W];
            res_status_in = req_invalid ? STATUS_INVALID : STATUS_OK;
            res_bit_in    = 1'b0;
            res_found_in  = '0;
         end
         ST_MODIFY: begin
            unique case (op_ff)
               OP_SET: begin
                  if (!cur_bit) begin
                     wr_en         = 1'b1;
                     wr_data       = word_q | bit_onehot;
                     set_count_in  = SIZE_W'(set_count_ff + 1'b1);
                     recent_set_in = idx_ff;
                  end
               end
               OP_CLEAR: begin
                  if (cur_bit) begin
                     wr_en           = 1'b1;
                     wr_data         = word_q & ~bit_onehot;
                     set_count_in    = SIZE_W'(set_count_ff - 1'b1);
                     recent_clear_in = idx_ff;
                  end
               end
               OP_TEST: begin
                  res_bit_in = cur_bit;
               end
               default: begin
                  res_bit_in = 1'b0;
               end
            endcase
         end
         ST_SEEK: begin
            if (out_of_room) begin
               res_found_in = size;
            end else if (seek_hit) begin
               cand_in = seek_cand;
            end else begin
               cand_in = next_word_cand;
               wrd_in  = next_word_cand[IDX_W-1:WORD_W];
            end
            rd_addr = wrd_in;
         end
         ST_CHECK: begin
            priority if (out_of_room) begin
               res_found_in = size;
            end else if (chk_hit) begin
               cand_in = jump_cand;
               wrd_in  = jump_cand[IDX_W-1:WORD_W];
            end else if (end_here) begin
               res_found_in = cand_ff;
            end else begin
               wrd_in = ROW_W'(wrd_ff + 1'b1);
            end
            rd_addr = wrd_in;
         end
         ST_DELIVER: begin
            rd_addr = wrd_ff;
         end
         default: begin
            rd_addr = wrd_ff;
         end
      endcase
   end

   // output register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DELIVER && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         map_size_ff     <= SIZE_W'(MAP_BITS);
         set_count_ff    <= '0;
         recent_set_ff   <= '0;
         recent_clear_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         set_count_ff    <= set_count_in;
         recent_set_ff   <= recent_set_in;
         recent_clear_ff <= recent_clear_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_write_enable) map_size_ff <= csr_write_data;
      end
   end

   // request context and result
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      mask_ff       <= mask_in;
      cand_ff       <= cand_in;
      wrd_ff        <= wrd_in;
      res_status_ff <= res_status_in;
      res_bit_ff    <= res_bit_in;
      res_found_ff  <= res_found_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_DELIVER && slot_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_bit_ff    <= res_bit_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= set_count_ff;
         rsp_set_ff    <= recent_set_ff;
         rsp_clear_ff  <= recent_clear_ff;
      end
   end

   // map words: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) map_mem[idx_ff[IDX_W-1:WORD_W]] <= wr_data;
      rd_data_ff <= map_mem[rd_addr];
   end

   // per-word valid bits; an unwritten word reads as clear
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) row_valid_ff[idx_ff[IDX_W-1:WORD_W]] <= 1'b1;
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_bit_value        = rsp_bit_ff;
   assign rsp_found_index      = rsp_found_ff;
   assign rsp_set_count        = rsp_count_ff;
   assign rsp_last_set_index   = rsp_set_ff;
   assign rsp_last_clear_index = rsp_clear_ff;

endmodule

`default_nettype wire

// File: rtl/baas_checker.sv
// port-level checks of the bitmap allocator, bound to the top level
// depends on baas_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_allocator_with_area_search_assert.svh"

module baas_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_status,
   input wire logic                        rsp_bit_value,
   input wire logic [baas_pkg::SIZE_W-1:0] rsp_found_index,
   input wire logic [baas_pkg::SIZE_W-1:0] rsp_set_count,
   input wire logic [baas_pkg::IDX_W-1:0]  rsp_last_set_index,
   input wire logic [baas_pkg::IDX_W-1:0]  rsp_last_clear_index
);
   import baas_pkg::*;

   logic                           rsp_rejected;
   logic                           rsp_blank;
   logic [2*SIZE_W+2*IDX_W+1:0]    rsp_payload;

   // result beat views
   assign rsp_rejected = rsp_valid && (rsp_status == STATUS_INVALID);
   assign rsp_blank    = !rsp_bit_value && (rsp_found_index == '0);
   assign rsp_payload  = {rsp_status, rsp_bit_value, rsp_found_index, rsp_set_count,
                          rsp_last_set_index, rsp_last_clear_index};

   // one request at a time: ready drops after a request beat
   `BAAS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a rejected request reports no bit value and no index
   `BAAS_ASSERT_NOW(a_invalid_clean, clock, reset, rsp_rejected, rsp_blank)

   // the set count never exceeds the map
   `BAAS_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_set_count <= SIZE_W'(MAP_BITS))

   // a search answer never lies past the map
   `BAAS_ASSERT_NOW(a_found_bound, clock, reset, rsp_valid, rsp_found_index <= SIZE_W'(MAP_BITS))

   // a stalled result beat holds
   `BAAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind bitmap_allocator_with_area_search baas_checker u_baas_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the bitmap allocator: a directed table then random allocate/free traffic
// checks every result beat against a cycle-free allocator predictor; depends on baas_pkg
`timescale 1ns / 1ps

module tb_top;
   import baas_pkg::*;

   // operation codes the block must reject
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 150;
   localparam int LONG_HOLD   = 400;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [IDX_W-1:0]  bit_index;
      logic [SIZE_W-1:0] run_length;
      logic [SIZE_W-1:0] alignment;
   } alloc_request_t;

   typedef struct packed {
      status_type        status;
      logic              bit_value;
      logic [SIZE_W-1:0] found_index;
      logic [SIZE_W-1:0] set_count;
      logic [IDX_W-1:0]  last_set_index;
      logic [IDX_W-1:0]  last_clear_index;
   } alloc_result_t;

   typedef struct packed {
      logic              is_config;
      logic [SIZE_W-1:0] size_value;
      alloc_request_t    rq;
      logic              hand_checked;
      alloc_result_t     want;
   } directed_row_t;

   // clock and block inputs, all known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [SIZE_W-1:0] csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic [OP_W-1:0]   req_operation = '0;
   logic [IDX_W-1:0]  req_bit_index = '0;
   logic [SIZE_W-1:0] req_run_length = '0;
   logic [SIZE_W-1:0] req_alignment = '0;
   logic              rsp_ready = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_status;
   logic              rsp_bit_value;
   logic [SIZE_W-1:0] rsp_found_index;
   logic [SIZE_W-1:0] rsp_set_count;
   logic [IDX_W-1:0]  rsp_last_set_index;
   logic [IDX_W-1:0]  rsp_last_clear_index;

   // predictor state
   bit                occupancy [MAP_BITS];
   logic [SIZE_W-1:0] ones_count = '0;
   logic [IDX_W-1:0]  recent_set_idx = '0;
   logic [IDX_W-1:0]  recent_clear_idx = '0;
   logic [SIZE_W-1:0] map_size_model = SIZE_W'(MAP_BITS);

   alloc_result_t     pending_results [$];
   alloc_result_t     last_outcome;
   directed_row_t     plan [$];
   int                mismatch_count = 0;
   int                hold_cycles = 0;
   bit                quiet_tail = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bitmap_allocator_with_area_search u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_bit_index        (req_bit_index),
      .req_run_length       (req_run_length),
      .req_alignment        (req_alignment),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_bit_value        (rsp_bit_value),
      .rsp_found_index      (rsp_found_index),
      .rsp_set_count        (rsp_set_count),
      .rsp_last_set_index   (rsp_last_set_index),
      .rsp_last_clear_index (rsp_last_clear_index)
   );

   // apply one request to the predicted map and return the beat it should give
   function automatic alloc_result_t allocator_step(alloc_request_t rq);
      alloc_result_t r;
      int unsigned   span, idx, len, aln, mask, p, i, found;
      bit            bad;
      span  = (map_size_model > MAP_BITS) ? MAP_BITS : map_size_model;
      idx   = rq.bit_index;
      len   = rq.run_length;
      aln   = rq.alignment;
      mask  = (aln != 0) ? aln - 1 : 0;
      found = 0;
      bad   = (rq.operation > OP_FIND_RUN) || (idx >= span);
      if (!bad && rq.operation == OP_FIND_RUN && (len == 0 || (aln & (aln - 1)) != 0))
         bad = 1'b1;
      r = '0;
      r.status = bad ? STATUS_INVALID : STATUS_OK;
      if (!bad) begin
         case (rq.operation)
            OP_SET: begin
               if (!occupancy[idx]) begin
                  occupancy[idx] = 1'b1;
                  ones_count++;
                  recent_set_idx = IDX_W'(idx);
               end
            end
            OP_CLEAR: begin
               if (occupancy[idx]) begin
                  occupancy[idx] = 1'b0;
                  ones_count--;
                  recent_clear_idx = IDX_W'(idx);
               end
            end
            OP_TEST: begin
               r.bit_value = occupancy[idx];
            end
            OP_FIND_ZERO: begin
               i = idx;
               while (i < span && occupancy[i]) i++;
               found = i;
            end
            default: begin
               // aligned run: skip past the first blocking bit and realign
               found = span;
               p = (idx + mask) & ~mask;
               while (p < span && len <= span - p && found == span) begin
                  i = p;
                  while (i < p + len && !occupancy[i]) i++;
                  if (i == p + len) found = p;
                  else p = (i + 1 + mask) & ~mask;
               end
            end
         endcase
      end
      r.found_index      = SIZE_W'(found);
      r.set_count        = ones_count;
      r.last_set_index   = recent_set_idx;
      r.last_clear_index = recent_clear_idx;
      return r;
   endfunction

   function automatic void note_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%s", what);
   endfunction

   // directed table rows
   function automatic directed_row_t ask(logic [OP_W-1:0] op, int unsigned idx,
                                         int unsigned len, int unsigned aln);
      directed_row_t row;
      row = '0;
      row.rq.operation  = op;
      row.rq.bit_index  = IDX_W'(idx);
      row.rq.run_length = SIZE_W'(len);
      row.rq.alignment  = SIZE_W'(aln);
      return row;
   endfunction

   function automatic directed_row_t known(directed_row_t row, status_type st, bit bv,
                                           int unsigned found, int unsigned cnt,
                                           int unsigned lset, int unsigned lclr);
      row.hand_checked          = 1'b1;
      row.want.status           = st;
      row.want.bit_value        = bv;
      row.want.found_index      = SIZE_W'(found);
      row.want.set_count        = SIZE_W'(cnt);
      row.want.last_set_index   = IDX_W'(lset);
      row.want.last_clear_index = IDX_W'(lclr);
      return row;
   endfunction

   function automatic directed_row_t resize(int unsigned v);
      directed_row_t row;
      row = '0;
      row.is_config  = 1'b1;
      row.size_value = SIZE_W'(v);
      return row;
   endfunction

   // drive one request beat from a falling edge, hold it until taken
   task automatic offer_request(alloc_request_t rq, bit hand_checked, alloc_result_t want);
      alloc_result_t predicted;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= rq.operation;
      req_bit_index  <= rq.bit_index;
      req_run_length <= rq.run_length;
      req_alignment  <= rq.alignment;
      do @(posedge clock); while (!req_ready);
      predicted    = allocator_step(rq);
      last_outcome = predicted;
      pending_results.push_back(hand_checked ? want : predicted);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding result beat
   task automatic wait_settled();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_map_size(logic [SIZE_W-1:0] v);
      wait_settled();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      map_size_model = v;
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int n;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin : result_check
      alloc_result_t seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status           = status_type'(rsp_status);
         seen.bit_value        = rsp_bit_value;
         seen.found_index      = rsp_found_index;
         seen.set_count        = rsp_set_count;
         seen.last_set_index   = rsp_last_set_index;
         seen.last_clear_index = rsp_last_clear_index;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result beat at %0t", $realtime));
         end else begin
            want = pending_results.pop_front();
            if (seen.status !== want.status || seen.bit_value !== want.bit_value ||
                seen.found_index !== want.found_index || seen.set_count !== want.set_count ||
                seen.last_set_index !== want.last_set_index ||
                seen.last_clear_index !== want.last_clear_index)
               note_failure($sformatf(
                  "beat at %0t: want st %0d bit %0d found %0d cnt %0d set %0d clr %0d, %s",
                  $realtime, want.status, want.bit_value, want.found_index, want.set_count,
                  want.last_set_index, want.last_clear_index,
                  $sformatf("got st %0d bit %0d found %0d cnt %0d set %0d clr %0d",
                     seen.status, seen.bit_value, seen.found_index, seen.set_count,
                     seen.last_set_index, seen.last_clear_index)));
         end
      end
   end

   initial begin : watchdog
      #100_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      alloc_request_t    rq;
      int unsigned       span, roll, len, aln, k;
      int                phase, target;
      logic [SIZE_W-1:0] new_size;

      // directed: empty map, extremes, rejects, run past the end, then size corners
      plan.push_back(known(ask(OP_TEST, 0, 0, 0), STATUS_OK, 0, 0, 0, 0, 0));
      plan.push_back(known(ask(OP_FIND_ZERO, 0, 0, 0), STATUS_OK, 0, 0, 0, 0, 0));
      plan.push_back(known(ask(OP_FIND_RUN, 0, 4096, 0), STATUS_OK, 0, 0, 0, 0, 0));
      plan.push_back(known(ask(OP_FIND_RUN, 1, 4096, 1), STATUS_OK, 0, 4096, 0, 0, 0));
      plan.push_back(known(ask(OP_SET, 4095, 0, 0), STATUS_OK, 0, 0, 1, 4095, 0));
      plan.push_back(known(ask(OP_SET, 4095, 0, 0), STATUS_OK, 0, 0, 1, 4095, 0));
      plan.push_back(known(ask(OP_SET, 0, 0, 0), STATUS_OK, 0, 0, 2, 0, 0));
      plan.push_back(known(ask(OP_TEST, 4095, 0, 0), STATUS_OK, 1, 0, 2, 0, 0));
      plan.push_back(known(ask(OP_FIND_ZERO, 4095, 0, 0), STATUS_OK, 0, 4096, 2, 0, 0));
      plan.push_back(known(ask(OP_SPARE_FIRST, 0, 0, 0), STATUS_INVALID, 0, 0, 2, 0, 0));
      plan.push_back(known(ask(OP_SPARE_LAST, 4095, 8191, 8191),
                           STATUS_INVALID, 0, 0, 2, 0, 0));
      plan.push_back(known(ask(OP_FIND_RUN, 0, 0, 0), STATUS_INVALID, 0, 0, 2, 0, 0));
      plan.push_back(known(ask(OP_FIND_RUN, 0, 1, 4095), STATUS_INVALID, 0, 0, 2, 0, 0));
      plan.push_back(ask(OP_SET, 64, 0, 0));
      plan.push_back(ask(OP_FIND_RUN, 60, 8, 4));
      plan.push_back(ask(OP_FIND_RUN, 1, 1, 4096));
      plan.push_back(ask(OP_FIND_RUN, 3, 8191, 0));
      plan.push_back(ask(OP_CLEAR, 4095, 0, 0));
      plan.push_back(ask(OP_CLEAR, 4095, 0, 0));
      plan.push_back(resize(0));
      plan.push_back(known(ask(OP_TEST, 0, 0, 0), STATUS_INVALID, 0, 0, 2, 64, 4095));
      plan.push_back(resize(8191));
      plan.push_back(ask(OP_FIND_ZERO, 4000, 0, 0));
      plan.push_back(resize(64));
      plan.push_back(ask(OP_SET, 63, 0, 0));
      plan.push_back(ask(OP_TEST, 64, 0, 0));
      plan.push_back(ask(OP_FIND_RUN, 0, 63, 2));
      plan.push_back(resize(1));
      plan.push_back(ask(OP_FIND_ZERO, 0, 0, 0));
      plan.push_back(ask(OP_CLEAR, 0, 0, 0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_config) write_map_size(plan[i].size_value);
         else offer_request(plan[i].rq, plan[i].hand_checked, plan[i].want);
      end

      // random phases, each at its own map size
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0 || phase == PHASES - 1) begin
            new_size = SIZE_W'(MAP_BITS);
         end else if (phase == 1) begin
            new_size = SIZE_W'(1);
         end else begin
            roll = $urandom_range(0, 7);
            if (roll == 0) new_size = SIZE_W'($urandom_range(2, 16));
            else if (roll == 1) new_size = SIZE_W'($urandom_range(MAP_BITS + 1, 2**SIZE_W - 1));
            else new_size = SIZE_W'($urandom_range(65, MAP_BITS));
         end
         write_map_size(new_size);
         quiet_tail = (phase == PHASES - 1);
         // block fills up behind a stalled result side
         if (phase == 3) hold_cycles = LONG_HOLD;
         span = (map_size_model > MAP_BITS) ? MAP_BITS : map_size_model;
         target = 0;
         while (target < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            rq.bit_index  = IDX_W'($urandom_range(0, span - 1));
            rq.run_length = SIZE_W'($urandom);
            rq.alignment  = SIZE_W'($urandom);
            if (roll < 8) begin
               // noise: any field value at all
               rq.operation = OP_W'($urandom_range(0, 2**OP_W - 1));
               rq.bit_index = IDX_W'($urandom);
               offer_request(rq, 1'b0, '0);
               target++;
            end else if (roll < 28) begin
               rq.operation = OP_SET;
               offer_request(rq, 1'b0, '0);
               target++;
            end else if (roll < 40) begin
               // free a short stretch now and then
               rq.operation = OP_CLEAR;
               len = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 8) : 1;
               for (k = 0; k < len && rq.bit_index + k < span; k++) begin
                  rq.bit_index = IDX_W'(rq.bit_index + ((k == 0) ? 0 : 1));
                  offer_request(rq, 1'b0, '0);
                  target++;
               end
            end else if (roll < 48) begin
               rq.operation = OP_TEST;
               offer_request(rq, 1'b0, '0);
               target++;
            end else if (roll < 64) begin
               rq.operation = OP_FIND_ZERO;
               offer_request(rq, 1'b0, '0);
               target++;
            end else begin
               rq.operation = OP_FIND_RUN;
               roll = $urandom_range(0, 9);
               if (roll < 7) len = $urandom_range(1, 16);
               else if (roll < 9) len = $urandom_range(17, 256);
               else len = $urandom_range(1, 2**SIZE_W - 1);
               roll = $urandom_range(0, 19);
               if (roll < 6) aln = 0;
               else if (roll < 17) aln = 1 << $urandom_range(0, 6);
               else if (roll < 19) aln = 1 << $urandom_range(7, IDX_W);
               else aln = $urandom_range(0, 2**SIZE_W - 1);
               rq.run_length = SIZE_W'(len);
               rq.alignment  = SIZE_W'(aln);
               offer_request(rq, 1'b0, '0);
               target++;
               // allocate the start of the run that was found
               if (last_outcome.status == STATUS_OK && last_outcome.found_index < span &&
                   $urandom_range(0, 1) == 1) begin
                  rq.operation = OP_SET;
                  for (k = 0; k < len && k < 8; k++) begin
                     rq.bit_index = IDX_W'(last_outcome.found_index + k);
                     offer_request(rq, 1'b0, '0);
                     target++;
                  end
               end
            end
         end
      end

      wait_settled();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
